// ----- hdl/gdp_pkg.sv -----
// ----------------------------------------------------------------------------
// gdp_pkg
// Shared types, constants and helpers for the gshare direction predictor.
// ----------------------------------------------------------------------------
`default_nettype none

package gdp_pkg;

    localparam int MAX_INDEX_BITS = 12;
    localparam int TABLE_DEPTH    = 1 << MAX_INDEX_BITS;
    localparam int LEN_W          = 4;
    localparam int PC_W           = 32;
    localparam int CTR_W          = 2;

    typedef logic [MAX_INDEX_BITS-1:0] idx_t;
    typedef logic [MAX_INDEX_BITS-1:0] hist_t;
    typedef logic [LEN_W-1:0]          len_t;
    typedef logic [CTR_W-1:0]          ctr_t;

    localparam ctr_t WEAK_TAKEN   = 2'd2;
    localparam ctr_t CTR_MAX      = 2'd3;
    localparam ctr_t CTR_MIN      = 2'd0;
    localparam len_t RESET_LENGTH = LEN_W'(MAX_INDEX_BITS);
    localparam len_t MIN_LENGTH   = LEN_W'(1);
    localparam idx_t LAST_INDEX   = MAX_INDEX_BITS'(TABLE_DEPTH - 1);

    localparam logic MODE_PREDICT = 1'b0;
    localparam logic MODE_RESOLVE = 1'b1;

    // Counter table write port
    typedef struct packed {
        logic en;
        idx_t addr;
        ctr_t data;
    } tbl_wr_t;

    // Clear sequencer status toward the core
    typedef struct packed {
        logic    busy;
        tbl_wr_t wr;
    } clr_t;

    function automatic len_t clamp_length(input len_t v);
        len_t r;
        if (v < MIN_LENGTH) begin
            r = MIN_LENGTH;
        end else if (v > RESET_LENGTH) begin
            r = RESET_LENGTH;
        end else begin
            r = v;
        end
        return r;
    endfunction

    function automatic hist_t len_mask(input len_t len);
        hist_t m;
        for (int i = 0; i < MAX_INDEX_BITS; i++) begin
            m[i] = (LEN_W'(i) < len);
        end
        return m;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/gdp_ifs.sv -----
// ----------------------------------------------------------------------------
// gdp_ifs
// Valid/ready channels for branch requests and prediction responses.
// ----------------------------------------------------------------------------
`default_nettype none

interface gdp_req_if;
    logic                      valid;
    logic                      ready;
    logic                      mode;
    logic [gdp_pkg::PC_W-1:0]  pc;
    logic                      taken;

    modport source (output valid, output mode, output pc, output taken, input ready);
    modport sink   (input valid, input mode, input pc, input taken, output ready);
endinterface

interface gdp_rsp_if;
    logic                      valid;
    logic                      ready;
    logic                      predict_taken;
    logic [gdp_pkg::CTR_W-1:0] counter_value;

    modport source (output valid, output predict_taken, output counter_value, input ready);
    modport sink   (input valid, input predict_taken, input counter_value, output ready);
endinterface

`default_nettype wire

// ----- hdl/gdp_ctr_table.sv -----
// ----------------------------------------------------------------------------
// gdp_ctr_table
// 2-bit counter memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module gdp_ctr_table (
    input  wire logic             clk,
    input  wire gdp_pkg::tbl_wr_t wr,
    input  wire logic             rd_en,
    input  wire gdp_pkg::idx_t    rd_addr,
    output gdp_pkg::ctr_t         rd_data
);

    gdp_pkg::ctr_t mem [gdp_pkg::TABLE_DEPTH];
    gdp_pkg::ctr_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    // read-before-write; holds when not enabled
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- hdl/gdp_clear.sv -----
// ----------------------------------------------------------------------------
// gdp_clear
// Sweeps every counter entry to weakly taken after reset and on restart.
// ----------------------------------------------------------------------------
`default_nettype none

module gdp_clear (
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   start,
    output gdp_pkg::clr_t clr
);

    logic          busy_reg;
    logic          busy_next;
    gdp_pkg::idx_t addr_reg;
    gdp_pkg::idx_t addr_next;

    always_comb
    begin
        busy_next = busy_reg;
        addr_next = addr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            addr_next = '0;
        end
        else if (busy_reg)
        begin
            addr_next = addr_reg + 1'b1;
            if (addr_reg == gdp_pkg::LAST_INDEX)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
            addr_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            addr_reg <= addr_next;
        end
    end

    assign clr.busy    = busy_reg;
    assign clr.wr.en   = busy_reg;
    assign clr.wr.addr = addr_reg;
    assign clr.wr.data = gdp_pkg::WEAK_TAKEN;

endmodule

`default_nettype wire

// ----- hdl/gshare_direction_predictor_unit.sv -----
// ----------------------------------------------------------------------------
// gshare_direction_predictor_unit
// gshare conditional-branch direction predictor with 2-bit counters.
// ----------------------------------------------------------------------------
// req carries one branch per transaction: mode (predict / resolve), pc and
// the actual outcome. rsp returns the counter read before any update and its
// taken bit. cfg_we/cfg_wdata write history_length (clamped to 1..12).
// Index = (pc ^ history) masked to history_length bits.
// One transaction per cycle sustained while rsp is ready and no clearing pass runs.
// The counter memory read is registered into the lookup stage, then into the
// response register; a response is valid once its lookup stage has advanced.
// A resolve writes back when it leaves the lookup stage, and a lookup of the
// same entry accepted at that edge takes the written value by forwarding.
// History updates on resolve acceptance; consecutive branches see it at once.
// After reset, and after every history_length write, a clearing pass writes
// all 4096 counters to weakly taken, one per cycle; req.ready stays low until
// the pass ends. History resets to zero; a length write keeps it.
// When rsp stalls, the response register holds, an occupied lookup stage holds
// and req.ready then drops until the response is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module gshare_direction_predictor_unit (
    input  wire logic          clk,
    input  wire logic          rst_n,
    gdp_req_if.sink            req,
    gdp_rsp_if.source          rsp,
    input  wire logic          cfg_we,
    input  wire gdp_pkg::len_t cfg_wdata
);

    gdp_pkg::clr_t    clr;
    gdp_pkg::tbl_wr_t pipe_wr;
    gdp_pkg::tbl_wr_t tbl_wr;
    gdp_pkg::ctr_t    rd_data;

    gdp_pkg::len_t  len_reg;
    gdp_pkg::len_t  len_next;
    gdp_pkg::hist_t hist_reg;
    gdp_pkg::hist_t hist_next;
    gdp_pkg::hist_t mask;

    logic           s1_valid_reg;
    logic           s1_valid_next;
    gdp_pkg::idx_t  s1_idx_reg;
    logic           s1_mode_reg;
    logic           s1_taken_reg;
    logic           fwd_hit_reg;
    gdp_pkg::ctr_t  fwd_ctr_reg;

    logic           out_valid_reg;
    logic           out_valid_next;
    gdp_pkg::ctr_t  out_ctr_reg;

    logic           accept;
    logic           s1_advance;
    gdp_pkg::idx_t  lookup_idx;
    gdp_pkg::ctr_t  s1_ctr;
    gdp_pkg::ctr_t  s1_new_ctr;

    gdp_clear u_clear (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cfg_we),
        .clr   (clr)
    );

    gdp_ctr_table u_table (
        .clk     (clk),
        .wr      (tbl_wr),
        .rd_en   (accept),
        .rd_addr (lookup_idx),
        .rd_data (rd_data)
    );

    assign mask       = gdp_pkg::len_mask(len_reg);
    assign lookup_idx = (req.pc[gdp_pkg::MAX_INDEX_BITS-1:0] ^ hist_reg) & mask;

    assign s1_advance = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready  = !clr.busy && (!s1_valid_reg || s1_advance);
    assign accept     = req.valid && req.ready;

    assign s1_ctr = fwd_hit_reg ? fwd_ctr_reg : rd_data;

    always_comb
    begin
        s1_new_ctr = s1_ctr;
        if (s1_taken_reg)
        begin
            if (s1_ctr != gdp_pkg::CTR_MAX)
            begin
                s1_new_ctr = s1_ctr + 1'b1;
            end
        end
        else if (s1_ctr != gdp_pkg::CTR_MIN)
        begin
            s1_new_ctr = s1_ctr - 1'b1;
        end
    end

    assign pipe_wr.en   = s1_advance && (s1_mode_reg == gdp_pkg::MODE_RESOLVE);
    assign pipe_wr.addr = s1_idx_reg;
    assign pipe_wr.data = s1_new_ctr;
    assign tbl_wr       = clr.busy ? clr.wr : pipe_wr;

    always_comb
    begin
        len_next       = len_reg;
        hist_next      = hist_reg;
        s1_valid_next  = s1_valid_reg;
        out_valid_next = out_valid_reg;
        if (cfg_we)
        begin
            len_next = gdp_pkg::clamp_length(cfg_wdata);
        end
        if (accept && (req.mode == gdp_pkg::MODE_RESOLVE))
        begin
            hist_next = {hist_reg[gdp_pkg::MAX_INDEX_BITS-2:0], req.taken} & mask;
        end
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_next = 1'b0;
        end
        if (s1_advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= gdp_pkg::RESET_LENGTH;
            hist_reg      <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            len_reg       <= len_next;
            hist_reg      <= hist_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_idx_reg   <= lookup_idx;
            s1_mode_reg  <= req.mode;
            s1_taken_reg <= req.taken;
            fwd_hit_reg  <= pipe_wr.en && (pipe_wr.addr == lookup_idx);
            fwd_ctr_reg  <= s1_new_ctr;
        end
        if (s1_advance)
        begin
            out_ctr_reg <= s1_ctr;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.counter_value = out_ctr_reg;
    assign rsp.predict_taken = out_ctr_reg[gdp_pkg::CTR_W-1];

endmodule

`default_nettype wire
